// File: rtl/kcrc_pkg.sv
`default_nettype none
package kcrc_pkg;

	localparam int MaxKmers  = 1024;
	localparam int ColorBits = 32;
	localparam int PosW      = $clog2(MaxKmers + 1);
	localparam int HitW      = $clog2(MaxKmers);
	localparam int CountW    = 32;
	localparam int NumEnds   = 2;
	localparam int NumScen   = 6;
	localparam int QDepth    = 4;
	localparam int QAw       = $clog2(QDepth);

	typedef enum logic [2:0] {
		ScenSame    = 3'd0,
		ScenDiffer  = 3'd1,
		ScenLow     = 3'd2,
		ScenMulti   = 3'd3,
		ScenTrimmed = 3'd4,
		ScenNone    = 3'd5
	} scen_t;

	typedef struct packed {
		scen_t                 scenario;
		logic [ColorBits-1:0]  component;
		logic [HitW-1:0]       trim_start;
		logic [HitW-1:0]       trim_end;
		logic [PosW-1:0]       found_total;
		logic [PosW-1:0]       kmer_total;
		logic                  too_long;
		logic                  read_end;
	} class_rec_t;

endpackage
`default_nettype wire

// File: rtl/kcrc_front.sv
`default_nettype none
module kcrc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic                           q_full,
	input  wire logic [kcrc_pkg::ColorBits-1:0] kmer_color,
	input  wire logic                           last_kmer,
	input  wire logic                           read_end,
	output logic                                rec_push,
	output kcrc_pkg::class_rec_t                rec
);

	logic [kcrc_pkg::ColorBits-1:0] first_q, latest_q, base_q;
	logic [kcrc_pkg::ColorBits-1:0] first_n, latest_n, base_n;
	logic                           have_base_q, multi_q, zero_q, over_q;
	logic                           have_base_n, multi_n, zero_n, over_n;
	logic [kcrc_pkg::PosW-1:0]      found_q, pos_q, found_n, pos_n;
	logic [kcrc_pkg::HitW-1:0]      first_hit_q, last_hit_q, first_hit_n, last_hit_n;
	logic                           accept;
	logic                           ends_found, low_found;

	assign accept = push && !q_full;

	always_comb begin
		first_n     = first_q;
		latest_n    = latest_q;
		base_n      = base_q;
		have_base_n = have_base_q;
		multi_n     = multi_q;
		zero_n      = zero_q;
		over_n      = over_q;
		found_n     = found_q;
		pos_n       = pos_q;
		first_hit_n = first_hit_q;
		last_hit_n  = last_hit_q;
		if (pos_q < kcrc_pkg::PosW'(kcrc_pkg::MaxKmers)) begin
			if (pos_q == '0) begin
				first_n = kmer_color;
			end
			latest_n = kmer_color;
			if (kmer_color == '0) begin
				zero_n = 1'b1;
			end else begin
				if (!have_base_q) begin
					have_base_n = 1'b1;
					base_n      = kmer_color;
					first_hit_n = pos_q[kcrc_pkg::HitW-1:0];
				end else if (kmer_color != base_q) begin
					multi_n = 1'b1;
				end
				last_hit_n = pos_q[kcrc_pkg::HitW-1:0];
				found_n    = found_q + 1'b1;
			end
			pos_n = pos_q + 1'b1;
		end else begin
			over_n = 1'b1;
		end
	end

	assign ends_found = (first_n != '0) && (latest_n != '0);
	assign low_found  = {found_n, 1'b0} < {1'b0, pos_n};

	always_comb begin
		rec             = '0;
		rec.found_total = found_n;
		rec.kmer_total  = pos_n;
		rec.too_long    = over_n;
		rec.read_end    = read_end;
		if (ends_found) begin
			if (first_n == latest_n) begin
				rec.scenario  = kcrc_pkg::ScenSame;
				rec.component = first_n;
			end else begin
				rec.scenario = kcrc_pkg::ScenDiffer;
			end
		end else if (low_found) begin
			rec.scenario = kcrc_pkg::ScenLow;
		end else if (zero_n && have_base_n && multi_n) begin
			rec.scenario = kcrc_pkg::ScenMulti;
		end else if (have_base_n && (zero_n != multi_n)) begin
			rec.scenario   = kcrc_pkg::ScenTrimmed;
			rec.component  = base_n;
			rec.trim_start = first_hit_n;
			rec.trim_end   = last_hit_n;
		end else begin
			rec.scenario = kcrc_pkg::ScenNone;
		end
	end

	assign rec_push = accept && last_kmer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= '0;
			latest_q    <= '0;
			base_q      <= '0;
			have_base_q <= 1'b0;
			multi_q     <= 1'b0;
			zero_q      <= 1'b0;
			over_q      <= 1'b0;
			found_q     <= '0;
			pos_q       <= '0;
			first_hit_q <= '0;
			last_hit_q  <= '0;
		end else if (accept) begin
			if (last_kmer) begin
				first_q     <= '0;
				latest_q    <= '0;
				base_q      <= '0;
				have_base_q <= 1'b0;
				multi_q     <= 1'b0;
				zero_q      <= 1'b0;
				over_q      <= 1'b0;
				found_q     <= '0;
				pos_q       <= '0;
				first_hit_q <= '0;
				last_hit_q  <= '0;
			end else begin
				first_q     <= first_n;
				latest_q    <= latest_n;
				base_q      <= base_n;
				have_base_q <= have_base_n;
				multi_q     <= multi_n;
				zero_q      <= zero_n;
				over_q      <= over_n;
				found_q     <= found_n;
				pos_q       <= pos_n;
				first_hit_q <= first_hit_n;
				last_hit_q  <= last_hit_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/kcrc_fifo.sv
`default_nettype none
module kcrc_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire kcrc_pkg::class_rec_t wr_data,
	output logic                      full,
	input  wire logic                 rd_en,
	output kcrc_pkg::class_rec_t      rd_data,
	output logic                      empty
);

	kcrc_pkg::class_rec_t             mem_q [kcrc_pkg::QDepth];
	logic [kcrc_pkg::QAw-1:0]         wr_ptr_q, rd_ptr_q;
	logic [kcrc_pkg::QAw:0]           count_q;
	logic                             do_wr, do_rd;

	assign full    = count_q == (kcrc_pkg::QAw+1)'(kcrc_pkg::QDepth);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (kcrc_pkg::QAw+1)'(do_wr) - (kcrc_pkg::QAw+1)'(do_rd);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (kcrc_pkg::QAw+1)'(kcrc_pkg::QDepth))
		else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[kcrc_pkg::QAw-1:0])
		else $error("queue pointers disagree with count");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a write");

endmodule
`default_nettype wire

// File: rtl/kcrc_back.sv
`default_nettype none
module kcrc_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_empty,
	input  wire kcrc_pkg::class_rec_t            q_data,
	output logic                                 q_pop,
	input  wire logic                            pop,
	output logic                                 empty,
	output logic [2:0]                           scenario,
	output logic                                 matched,
	output logic [kcrc_pkg::ColorBits-1:0]       component,
	output logic [kcrc_pkg::HitW-1:0]            trim_start,
	output logic [kcrc_pkg::HitW-1:0]            trim_end,
	output logic [kcrc_pkg::PosW-1:0]            found_total,
	output logic [kcrc_pkg::PosW-1:0]            kmer_total,
	output logic [kcrc_pkg::CountW-1:0]          scenario_total,
	output logic                                 too_long
);

	logic [kcrc_pkg::CountW-1:0] counts_q [kcrc_pkg::NumEnds][kcrc_pkg::NumScen];
	logic                        out_valid_q;
	kcrc_pkg::class_rec_t        out_q;
	logic [kcrc_pkg::CountW-1:0] total_q;
	logic [kcrc_pkg::CountW-1:0] cur, nxt;

	assign q_pop = !q_empty && (!out_valid_q || pop);
	assign cur   = counts_q[q_data.read_end][q_data.scenario];
	assign nxt   = (cur == '1) ? cur : cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int e = 0; e < kcrc_pkg::NumEnds; e++) begin
				for (int s = 0; s < kcrc_pkg::NumScen; s++) begin
					counts_q[e][s] <= '0;
				end
			end
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				counts_q[q_data.read_end][q_data.scenario] <= nxt;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q   <= q_data;
			total_q <= nxt;
		end
	end

	assign empty          = !out_valid_q;
	assign scenario       = out_q.scenario;
	assign matched        = (out_q.scenario == kcrc_pkg::ScenSame) ||
	                        (out_q.scenario == kcrc_pkg::ScenTrimmed);
	assign component      = out_q.component;
	assign trim_start     = out_q.trim_start;
	assign trim_end       = out_q.trim_end;
	assign found_total    = out_q.found_total;
	assign kmer_total     = out_q.kmer_total;
	assign scenario_total = total_q;
	assign too_long       = out_q.too_long;

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (total_q != '0))
		else $error("delivered counter is zero");
	a_unmatched_no_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !matched) |-> (component == '0))
		else $error("component set on unmatched item");
	a_found_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (found_total <= kmer_total))
		else $error("found count above k-mer count");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(total_q)))
		else $error("waiting result changed");

endmodule
`default_nettype wire

// File: rtl/kmer_color_read_classifier.sv
`default_nettype none
// channel   handshake        fields
// input     push / full      kmer_color, last_kmer, read_end
// result    empty / pop      scenario, matched, component, trim_start, trim_end,
//                            found_total, kmer_total, scenario_total, too_long
// one k-mer accepted per cycle while not full; per-read state updates same cycle
// a final k-mer's classification is queued, then the counter update and result
// register load it from the queue when that register is empty or being popped
// full rises only when the four-entry queue between front and back is full
// asynchronous reset clears per-read state, counters, queue and result valid flag
module kmer_color_read_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [kcrc_pkg::ColorBits-1:0] kmer_color,
	input  wire logic                           last_kmer,
	input  wire logic                           read_end,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [2:0]                          scenario,
	output logic                                matched,
	output logic [kcrc_pkg::ColorBits-1:0]      component,
	output logic [kcrc_pkg::HitW-1:0]           trim_start,
	output logic [kcrc_pkg::HitW-1:0]           trim_end,
	output logic [kcrc_pkg::PosW-1:0]           found_total,
	output logic [kcrc_pkg::PosW-1:0]           kmer_total,
	output logic [kcrc_pkg::CountW-1:0]         scenario_total,
	output logic                                too_long
);

	logic                 rec_push, q_full, q_empty, q_pop;
	kcrc_pkg::class_rec_t rec, q_data;

	assign full = q_full;

	kcrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (q_full),
		.kmer_color (kmer_color),
		.last_kmer  (last_kmer),
		.read_end   (read_end),
		.rec_push   (rec_push),
		.rec        (rec)
	);

	kcrc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	kcrc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_data),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.scenario       (scenario),
		.matched        (matched),
		.component      (component),
		.trim_start     (trim_start),
		.trim_end       (trim_end),
		.found_total    (found_total),
		.kmer_total     (kmer_total),
		.scenario_total (scenario_total),
		.too_long       (too_long)
	);

endmodule
`default_nettype wire
